// File: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

    localparam int WORD_BYTES = 8;
    localparam int WB_SHIFT   = 3;
    localparam int CFG_W      = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
    localparam int MIN_POOL   = 3;

    // Widest memory port the parameter range can ask for.
    localparam int PORT_AW = 17;
    localparam int PORT_DW = 19;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_TOTAL   = 2'd2;
    localparam logic [1:0] REQ_LARGEST = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FAIL   = 2'd1;
    localparam logic [1:0] STAT_DOUBLE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [13:0] size_bytes;
        logic [12:0] free_addr;
    } req_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] alloc_addr;
        logic [13:0] query_bytes;
    } rsp_beat_t;

    typedef struct packed {
        logic               rd_en;
        logic [PORT_AW-1:0] rd_addr;
        logic               wr_en;
        logic [PORT_AW-1:0] wr_addr;
        logic [PORT_DW-1:0] wr_data;
    } mem_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_HDR,
        S_MERGE,
        S_FIT,
        S_SPLIT,
        S_DONE
    } seq_state_t;

endpackage
`default_nettype wire

// File: rtl/ffba_store.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_store
    import ffba_pkg::*;
#(
    parameter int POOL_WORDS = 1024,
    parameter int HW         = 13
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rebuild,
    input  wire logic signed [HW-1:0] init_hdr,
    input  wire mem_cmd_t             cmd,
    output logic signed [HW-1:0]      rd_data
);
    localparam int IW = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;

    logic signed [HW-1:0] mem [POOL_WORDS];
    logic signed [HW-1:0] q_reg;
    logic                 hit_reg;
    logic                 ovr_reg;
    logic                 ovr_next;
    logic [IW-1:0]        rd_idx;
    logic [IW-1:0]        wr_idx;

    assign rd_idx = cmd.rd_addr[IW-1:0];
    assign wr_idx = cmd.wr_addr[IW-1:0];

    // Word one reads as the fresh pool header until it is written.
    always_comb
    begin
        ovr_next = ovr_reg;
        if (cmd.wr_en && cmd.wr_addr == PORT_AW'(1))
            ovr_next = 1'b0;
        if (rebuild)
            ovr_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovr_reg <= 1'b1;
            hit_reg <= 1'b0;
        end
        else
        begin
            ovr_reg <= ovr_next;
            hit_reg <= cmd.rd_en && cmd.rd_addr == PORT_AW'(1) && ovr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_idx] <= cmd.wr_data[HW-1:0];
        if (cmd.rd_en)
            q_reg <= mem[rd_idx];
    end

    assign rd_data = hit_reg ? init_hdr : q_reg;

endmodule
`default_nettype wire

// File: rtl/ffba_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module ffba_seq
    import ffba_pkg::*;
#(
    parameter int WW = 13
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [WW-1:0]        pool,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire req_beat_t            req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output rsp_beat_t                 rsp,
    output mem_cmd_t                  cmd,
    input  wire logic signed [WW-1:0] rd_data
);
    seq_state_t state_reg, state_next;

    logic [1:0]    op_reg, op_next;
    logic [WW-1:0] need_reg, need_next;
    logic [WW-1:0] t_reg, t_next;
    logic [WW-1:0] h_reg, h_next;
    logic [WW-1:0] s_reg, s_next;
    logic [WW-1:0] nx_reg, nx_next;
    logic [WW-1:0] total_reg, total_next;
    logic [WW-1:0] best_reg, best_next;
    logic [1:0]    stat_reg, stat_next;
    logic [12:0]   addr_reg, addr_next;
    logic          ovalid_reg, ovalid_next;
    rsp_beat_t     rsp_reg, rsp_next;

    logic          accept;
    logic          out_free;
    logic [14:0]   need_wide;
    logic [9:0]    free_word;
    logic [WW-1:0] fw, tw;
    logic          free_ok;
    logic [WW-1:0] len;
    logic [WW-1:0] h_step;
    logic [WW-1:0] nx_first;
    logic [WW-1:0] nx_merge;
    logic [WW-1:0] q_words;
    logic [WW+2:0] q_bytes;
    logic [WW+2:0] a_bytes;

    assign accept   = state_reg == S_IDLE && req_valid;
    assign req_stall = state_reg != S_IDLE;
    assign out_free = !ovalid_reg || !rsp_stall;

    assign need_wide = ({1'b0, req.size_bytes} + 15'(WORD_BYTES - 1)) >> WB_SHIFT;
    assign free_word = req.free_addr[12:WB_SHIFT];
    assign fw        = WW'(free_word);
    assign free_ok   = req.free_addr[WB_SHIFT-1:0] == '0 && fw >= WW'(2) && fw <= pool;
    assign tw        = fw - WW'(1);

    assign len      = rd_data[WW-1] ? WW'(-rd_data) : WW'(rd_data);
    assign h_step   = h_reg + len + WW'(1);
    assign nx_first = h_reg + WW'(rd_data) + WW'(1);
    assign nx_merge = nx_reg + WW'(rd_data) + WW'(1);

    assign q_words = (op_reg == REQ_TOTAL) ? total_reg : best_reg;
    assign q_bytes = {q_words, 3'b000};
    assign a_bytes = {h_reg + WW'(1), 3'b000};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_ALLOC && need_wide == '0)
                        state_next = S_DONE;
                    else if (req.req_type == REQ_FREE && !free_ok)
                        state_next = S_DONE;
                    else
                        state_next = S_READ;
                end
            end
            S_READ:
                state_next = (h_reg >= pool) ? S_DONE : S_HDR;
            S_HDR:
            begin
                if (op_reg == REQ_FREE)
                begin
                    if (t_reg >= h_reg && t_reg <= h_reg + len)
                        state_next = S_DONE;
                    else
                        state_next = S_READ;
                end
                else if (rd_data[WW-1])
                    state_next = S_READ;
                else if (nx_first < pool)
                    state_next = S_MERGE;
                else
                    state_next = S_FIT;
            end
            S_MERGE:
            begin
                if (rd_data[WW-1] || nx_merge >= pool)
                    state_next = S_FIT;
            end
            S_FIT:
            begin
                if (op_reg == REQ_ALLOC && s_reg >= need_reg)
                    state_next = (s_reg > need_reg) ? S_SPLIT : S_DONE;
                else
                    state_next = S_READ;
            end
            S_SPLIT:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        need_next   = need_reg;
        t_next      = t_reg;
        h_next      = h_reg;
        s_next      = s_reg;
        nx_next     = nx_reg;
        total_next  = total_reg;
        best_next   = best_reg;
        stat_next   = stat_reg;
        addr_next   = addr_reg;
        rsp_next    = rsp_reg;
        ovalid_next = ovalid_reg && rsp_stall;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.req_type;
                    need_next  = WW'(need_wide);
                    t_next     = tw;
                    h_next     = WW'(1);
                    total_next = '0;
                    best_next  = '0;
                    stat_next  = (req.req_type == REQ_ALLOC || req.req_type == REQ_FREE)
                                 ? STAT_FAIL : STAT_OK;
                    addr_next  = '0;
                end
            end
            S_READ:
            begin
                cmd.rd_en   = h_reg < pool;
                cmd.rd_addr = PORT_AW'(h_reg);
            end
            S_HDR:
            begin
                if (op_reg == REQ_FREE)
                begin
                    if (t_reg >= h_reg && t_reg <= h_reg + len)
                    begin
                        if (!rd_data[WW-1])
                            stat_next = STAT_DOUBLE;
                        else if (t_reg == h_reg)
                        begin
                            stat_next   = STAT_OK;
                            cmd.wr_en   = 1'b1;
                            cmd.wr_addr = PORT_AW'(h_reg);
                            cmd.wr_data = PORT_DW'(-rd_data);
                        end
                    end
                    else
                        h_next = h_step;
                end
                else if (rd_data[WW-1])
                    h_next = h_step;
                else
                begin
                    s_next  = WW'(rd_data);
                    nx_next = nx_first;
                    cmd.rd_en   = nx_first < pool;
                    cmd.rd_addr = PORT_AW'(nx_first);
                end
            end
            S_MERGE:
            begin
                if (!rd_data[WW-1])
                begin
                    // absorb the following free block and look one further
                    s_next  = s_reg + WW'(rd_data) + WW'(1);
                    nx_next = nx_merge;
                    cmd.rd_en   = nx_merge < pool;
                    cmd.rd_addr = PORT_AW'(nx_merge);
                end
            end
            S_FIT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = PORT_AW'(h_reg);
                if (op_reg == REQ_ALLOC && s_reg >= need_reg)
                begin
                    stat_next = STAT_OK;
                    addr_next = a_bytes[12:0];
                    cmd.wr_data = (s_reg > need_reg) ? PORT_DW'(-$signed(need_reg))
                                                     : PORT_DW'(-$signed(s_reg));
                end
                else
                begin
                    cmd.wr_data = PORT_DW'(s_reg);
                    total_next  = total_reg + s_reg;
                    if (s_reg > best_reg)
                        best_next = s_reg;
                    h_next = h_reg + s_reg + WW'(1);
                end
            end
            S_SPLIT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = PORT_AW'(h_reg + need_reg + WW'(1));
                cmd.wr_data = PORT_DW'(s_reg - need_reg - WW'(1));
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next      = 1'b1;
                    rsp_next.status  = stat_reg;
                    rsp_next.alloc_addr = addr_reg;
                    rsp_next.query_bytes = (op_reg == REQ_TOTAL || op_reg == REQ_LARGEST)
                                           ? q_bytes[13:0] : 14'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        need_reg  <= need_next;
        t_reg     <= t_next;
        h_reg     <= h_next;
        s_reg     <= s_next;
        nx_reg    <= nx_next;
        total_reg <= total_next;
        best_reg  <= best_next;
        stat_reg  <= stat_next;
        addr_reg  <= addr_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = ovalid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// File: rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// First-fit allocator over a pool of 8-byte words kept in an on-chip header memory.
// Request channel (req_valid/req_stall/req): one beat is an allocate, free,
// total-free or largest-free request. Response channel (rsp_valid/rsp_stall/rsp):
// exactly one beat per request, in order.
// Each request walks the block headers from word one, one memory read per header.
// An allocated header, and any header checked by a free, takes a read and a
// check; a free header seen by an allocate or a query adds a neighbor read and
// a write-back, without the neighbor read when it ends at the pool end, plus a
// check per merged neighbor; a split adds a write of the remainder header.
// Acceptance and loading the result come on top. The single read port of the
// header memory sets this. A rejected request goes straight to the result load.
// req_stall is high from acceptance until the result is loaded into the
// response register. A waiting response does not block the next request; only
// loading the following result waits on rsp_stall.
// cfg_we writes the pool size and rebuilds the pool as one free block at once,
// and must only be used while no request is in flight.
// Reset sets the pool size to 1024 words with one free block; no clearing pass.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int POOL_WORDS = 1024
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire req_beat_t        req,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output rsp_beat_t             rsp
);
    localparam int AW = $clog2(POOL_WORDS + 1);
    localparam int WW = (AW + 2 > 13) ? AW + 2 : 13;

    logic [CFG_W-1:0]     pool_reg;
    logic [WW-1:0]        pool_eff;
    logic signed [WW-1:0] init_hdr;
    logic signed [WW-1:0] rd_data;
    mem_cmd_t             cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pool_reg <= CFG_RESET;
        else if (cfg_we)
            pool_reg <= cfg_wdata;
    end

    always_comb
    begin
        if (WW'(pool_reg) < WW'(MIN_POOL))
            pool_eff = WW'(MIN_POOL);
        else if (WW'(pool_reg) > WW'(POOL_WORDS))
            pool_eff = WW'(POOL_WORDS);
        else
            pool_eff = WW'(pool_reg);
    end

    assign init_hdr = $signed(pool_eff - WW'(2));

    ffba_store #(
        .POOL_WORDS (POOL_WORDS),
        .HW         (WW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rebuild  (cfg_we),
        .init_hdr (init_hdr),
        .cmd      (cmd),
        .rd_data  (rd_data)
    );

    ffba_seq #(
        .WW (WW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool      (pool_eff),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cmd       (cmd),
        .rd_data   (rd_data)
    );

endmodule
`default_nettype wire
